// ===== hdl/pmfe_pkg.sv =====
// ----------------------------------------------------------------------------
// Probe meter front end package
// Shared widths, register indexes, meter modes, rounding shift codes and the
// transaction types of the item, result and multiply channels.
// ----------------------------------------------------------------------------
package pmfe_pkg;

	localparam int ADC_BITS = 12;

	localparam int CW    = (ADC_BITS > 12) ? ADC_BITS : 12;
	localparam int MB_W  = (CW + 6 > 18) ? CW + 6 : 18;
	localparam int A_W   = 33;
	localparam int P_W   = A_W + MB_W;
	localparam int DV_W  = 30;
	localparam int DC_W  = $clog2(DV_W + 1);

	localparam logic [2:0] REG_UPDATE_PERIOD = 3'd0;
	localparam logic [2:0] REG_REF_CAL       = 3'd1;
	localparam logic [2:0] REG_PROBE_OFFSET  = 3'd2;
	localparam logic [2:0] REG_PROBE_WEIGHT  = 3'd3;
	localparam logic [2:0] REG_SUPPLY_WEIGHT = 3'd4;
	localparam logic [2:0] REG_SHORT_THRESH  = 3'd5;
	localparam logic [2:0] REG_DIODE_THRESH  = 3'd6;
	localparam logic [2:0] REG_BEEP_ON_TICKS = 3'd7;

	localparam logic [1:0] MODE_VOLT       = 2'd0;
	localparam logic [1:0] MODE_CONTINUITY = 2'd1;
	localparam logic [1:0] MODE_JUNCTION   = 2'd2;

	localparam logic       OP_TICK   = 1'b0;
	localparam logic       OP_SAMPLE = 1'b1;

	localparam logic [16:0]        Q_ONE      = 17'h10000;
	localparam logic signed [32:0] FIVE_VOLTS = 33'sd327680;
	localparam logic [30:0]        VREF_MAX   = 31'h7FFF_FFFF;

	typedef enum logic [1:0] {
		SH_ADC  = 2'd0,
		SH_ADC1 = 2'd1,
		SH_Q16  = 2'd2
	} sh_sel_t;

	typedef struct packed {
		logic                operation;
		logic [ADC_BITS-1:0] probe_code;
		logic [ADC_BITS-1:0] battery_code;
		logic [ADC_BITS-1:0] reference_code;
		logic                key_pressed;
	} item_t;

	typedef struct packed {
		logic               buzzer_on;
		logic               sample_due;
		logic [1:0]         meter_mode;
		logic signed [31:0] probe_volts;
		logic signed [31:0] battery_volts;
		logic signed [31:0] third_value;
		logic               beep_request;
	} result_t;

	typedef struct packed {
		logic                    start;
		sh_sel_t                 sh;
		logic signed [A_W-1:0]   a;
		logic signed [MB_W-1:0]  b;
		logic signed [32:0]      addend;
	} mac_req_t;

	typedef struct packed {
		logic               valid;
		logic signed [31:0] value;
	} mac_rsp_t;

endpackage

// ===== hdl/pmfe_div.sv =====
// ----------------------------------------------------------------------------
// Probe meter restoring divider
// Unsigned division, one quotient bit per cycle, pulses done when finished.
// ----------------------------------------------------------------------------
module pmfe_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [pmfe_pkg::DV_W-1:0]     dividend,
	input  logic [pmfe_pkg::ADC_BITS-1:0] divisor,
	output logic                          done,
	output logic [pmfe_pkg::DV_W-1:0]     quotient
);
	import pmfe_pkg::*;

	logic [DV_W-1:0]     quo_q;
	logic [ADC_BITS-1:0] rem_q;
	logic [ADC_BITS-1:0] dsr_q;
	logic [DC_W-1:0]     cnt_q;
	logic                done_q;
	logic [ADC_BITS:0]   shifted;
	logic [ADC_BITS:0]   diff;
	logic                ge;

	always_comb begin
		shifted = {rem_q, quo_q[DV_W-1]};
		ge      = shifted >= {1'b0, dsr_q};
		diff    = shifted - {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= DC_W'(DV_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == DC_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[ADC_BITS-1:0] : shifted[ADC_BITS-1:0];
			quo_q <= {quo_q[DV_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== hdl/pmfe_mac.sv =====
// ----------------------------------------------------------------------------
// Probe meter multiply unit
// Four-stage multiply, round-to-nearest shift, accumulate and saturate to the
// signed 32-bit range.
// ----------------------------------------------------------------------------
module pmfe_mac (
	input  logic               clk,
	input  logic               arst_n,
	input  pmfe_pkg::mac_req_t req,
	output pmfe_pkg::mac_rsp_t rsp
);
	import pmfe_pkg::*;

	localparam logic [P_W-1:0] HALF_ADC  = P_W'(1) << (ADC_BITS - 1);
	localparam logic [P_W-1:0] HALF_ADC1 = P_W'(1) << ADC_BITS;
	localparam logic [P_W-1:0] HALF_Q16  = P_W'(1) << 15;

	logic                   v_s1, v_s2, v_s3, v_s4;
	logic signed [P_W-1:0]  prod_s1;
	sh_sel_t                sh_s1, sh_s2;
	logic signed [32:0]     add_s1, add_s2, add_s3;
	logic [P_W-1:0]         mag_s2, mag_s3;
	logic                   neg_s2, neg_s3;
	logic signed [31:0]     value_s4;
	logic [P_W-1:0]         mag_r;
	logic signed [P_W:0]    rs;
	logic signed [P_W:0]    sum;
	logic signed [31:0]     sat;

	always_comb begin
		case (sh_s2)
			SH_ADC:  mag_r = (mag_s2 + HALF_ADC) >> ADC_BITS;
			SH_ADC1: mag_r = (mag_s2 + HALF_ADC1) >> (ADC_BITS + 1);
			SH_Q16:  mag_r = (mag_s2 + HALF_Q16) >> 16;
			default: mag_r = (mag_s2 + HALF_Q16) >> 16;
		endcase
	end

	always_comb begin
		rs  = neg_s3 ? -$signed({1'b0, mag_s3}) : $signed({1'b0, mag_s3});
		sum = rs + (P_W + 1)'(add_s3);
		if (!sum[P_W] && (|sum[P_W-1:31])) begin
			sat = 32'sh7FFF_FFFF;
		end else if (sum[P_W] && !(&sum[P_W-1:31])) begin
			sat = -32'sh7FFF_FFFF - 32'sd1;
		end else begin
			sat = sum[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= req.start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1  <= P_W'(req.a) * P_W'(req.b);
		sh_s1    <= req.sh;
		add_s1   <= req.addend;
		mag_s2   <= prod_s1[P_W-1] ? P_W'(-prod_s1) : P_W'(prod_s1);
		neg_s2   <= prod_s1[P_W-1];
		sh_s2    <= sh_s1;
		add_s2   <= add_s1;
		mag_s3   <= mag_r;
		neg_s3   <= neg_s2;
		add_s3   <= add_s2;
		value_s4 <= sat;
	end

	assign rsp.valid = v_s4;
	assign rsp.value = value_s4;

endmodule

// ===== hdl/probe_meter_front_end.sv =====
// ----------------------------------------------------------------------------
// Probe meter front end
// Tick and sample processing: buzzer pattern, sample-due flag, supply
// reference, battery and probe voltages with exponential averaging.
// ----------------------------------------------------------------------------
// A tick transaction goes from acceptance through the done step, which waits on
// result_stall, to a result in the output register. A sample transaction runs
// the bit-serial supply reference division and then five passes through the
// shared four-stage multiply unit (battery and probe scaling, then the three
// averages). item_stall is high from acceptance until the result is loaded;
// a new transaction is accepted while the previous result waits on
// result_stall. Configuration writes are always taken (cfg_ready is high) and
// are meant to be issued only while the block is idle.
module probe_meter_front_end (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  pmfe_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output pmfe_pkg::result_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [30:0]       cfg_data
);
	import pmfe_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_DIV   = 8'b0000_0010,
		S_BATT  = 8'b0000_0100,
		S_PROBE = 8'b0000_1000,
		S_BREF  = 8'b0001_0000,
		S_BBAT  = 8'b0010_0000,
		S_BPRB  = 8'b0100_0000,
		S_DONE  = 8'b1000_0000
	} state_t;

	state_t              state_q;
	logic                issued_q;

	logic [15:0]         update_period_q;
	logic [11:0]         ref_cal_q;
	logic [11:0]         probe_offset_q;
	logic [16:0]         probe_weight_q;
	logic [16:0]         supply_weight_q;
	logic [30:0]         short_thresh_q;
	logic [30:0]         diode_thresh_q;
	logic [7:0]          beep_on_q;

	logic [15:0]         tick_count_q;
	logic [7:0]          buzzer_count_q;
	logic                buzzer_level_q;
	logic                beep_flag_q;
	logic [1:0]          mode_q;
	logic                first_q;
	logic signed [31:0]  avg_probe_q;
	logic signed [31:0]  avg_battery_q;
	logic signed [31:0]  avg_ref_q;

	logic [ADC_BITS-1:0] probe_q;
	logic [ADC_BITS-1:0] batt_q;
	logic                ref_zero_q;
	logic                key_q;
	logic [30:0]         vref_q;
	logic signed [31:0]  vbatt_q;
	logic signed [31:0]  vprobe_q;

	result_t             result_q;
	logic                result_valid_q;

	logic                accept;
	logic                div_start;
	logic                div_done;
	logic [DV_W-1:0]     div_quo;
	logic [DV_W-1:0]     dividend;
	logic [13:0]         cal3;
	mac_req_t            mac_req;
	mac_rsp_t            mac_rsp;
	logic                mac_state;

	logic signed [CW:0]     pd;
	logic signed [MB_W-1:0] pd_x;
	logic [16:0]            w_probe;
	logic [16:0]            w_supply;
	logic signed [32:0]     avg_ref_x, avg_bat_x, avg_prb_x;

	logic [8:0]          buzz_next;
	logic [1:0]          mode_n;
	logic                beep_n;
	logic signed [32:0]  raw_probe;

	assign accept     = item_valid && !item_stall;
	assign item_stall = (state_q != S_IDLE);
	assign cfg_ready  = 1'b1;
	assign div_start  = accept && (item.operation == OP_SAMPLE);
	assign cal3       = {1'b0, ref_cal_q, 1'b0} + {2'b00, ref_cal_q};
	assign dividend   = DV_W'({cal3, 16'h0000}) + DV_W'(item.reference_code >> 1);
	assign buzz_next  = {1'b0, buzzer_count_q} + 9'd1;

	pmfe_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (item.reference_code),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		pd        = $signed((CW + 1)'(probe_q)) - $signed((CW + 1)'(probe_offset_q));
		pd_x      = MB_W'(pd);
		w_probe   = first_q ? Q_ONE : (probe_weight_q[16] ? Q_ONE : probe_weight_q);
		w_supply  = first_q ? Q_ONE : (supply_weight_q[16] ? Q_ONE : supply_weight_q);
		avg_ref_x = 33'(avg_ref_q);
		avg_bat_x = 33'(avg_battery_q);
		avg_prb_x = 33'(avg_probe_q);
		mac_state = (state_q == S_BATT) || (state_q == S_PROBE) || (state_q == S_BREF) ||
			(state_q == S_BBAT) || (state_q == S_BPRB);

		mac_req.start  = mac_state && !issued_q;
		mac_req.sh     = SH_Q16;
		mac_req.a      = $signed(A_W'(vref_q));
		mac_req.b      = '0;
		mac_req.addend = '0;
		case (state_q)
			S_BATT: begin
				mac_req.sh = SH_ADC;
				mac_req.b  = $signed(MB_W'({batt_q, 1'b0}));
			end
			S_PROBE: begin
				mac_req.sh = SH_ADC1;
				mac_req.b  = (pd_x <<< 4) + pd_x;
			end
			S_BREF: begin
				mac_req.a      = $signed(A_W'(vref_q)) - avg_ref_x;
				mac_req.b      = $signed(MB_W'(w_supply));
				mac_req.addend = avg_ref_x;
			end
			S_BBAT: begin
				mac_req.a      = 33'(vbatt_q) - avg_bat_x;
				mac_req.b      = $signed(MB_W'(w_supply));
				mac_req.addend = avg_bat_x;
			end
			S_BPRB: begin
				mac_req.a      = 33'(vprobe_q) - avg_prb_x;
				mac_req.b      = $signed(MB_W'(w_probe));
				mac_req.addend = avg_prb_x;
			end
			default: begin
				mac_req.sh = SH_Q16;
			end
		endcase
	end

	pmfe_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mac_req),
		.rsp    (mac_rsp)
	);

	always_comb begin
		mode_n    = mode_q;
		beep_n    = beep_flag_q;
		raw_probe = 33'(mac_rsp.value);
		if (key_q) begin
			mode_n = mode_q[1] ? MODE_VOLT : mode_q + 2'd1;
			beep_n = 1'b0;
			if (mode_n != MODE_VOLT) begin
				raw_probe = FIVE_VOLTS;
			end
		end
		if (mode_n == MODE_CONTINUITY) begin
			beep_n = raw_probe < $signed({2'b00, short_thresh_q});
		end else if (mode_n == MODE_JUNCTION) begin
			beep_n = raw_probe < $signed({2'b00, diode_thresh_q});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			update_period_q <= 16'd50;
			ref_cal_q       <= 12'd1650;
			probe_offset_q  <= 12'd50;
			probe_weight_q  <= 17'd32768;
			supply_weight_q <= 17'd13107;
			short_thresh_q  <= 31'd32768;
			diode_thresh_q  <= 31'd65536;
			beep_on_q       <= 8'd5;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_UPDATE_PERIOD: update_period_q <= cfg_data[15:0];
				REG_REF_CAL:       ref_cal_q       <= cfg_data[11:0];
				REG_PROBE_OFFSET:  probe_offset_q  <= cfg_data[11:0];
				REG_PROBE_WEIGHT:  probe_weight_q  <= cfg_data[16:0];
				REG_SUPPLY_WEIGHT: supply_weight_q <= cfg_data[16:0];
				REG_SHORT_THRESH:  short_thresh_q  <= cfg_data;
				REG_DIODE_THRESH:  diode_thresh_q  <= cfg_data;
				REG_BEEP_ON_TICKS: beep_on_q       <= cfg_data[7:0];
				default:           beep_on_q       <= beep_on_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			issued_q       <= 1'b0;
			tick_count_q   <= '0;
			buzzer_count_q <= '0;
			buzzer_level_q <= 1'b0;
			beep_flag_q    <= 1'b0;
			mode_q         <= MODE_VOLT;
			first_q        <= 1'b1;
			avg_probe_q    <= '0;
			avg_battery_q  <= '0;
			avg_ref_q      <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (result_valid_q && !result_stall && (state_q != S_DONE)) begin
				result_valid_q <= 1'b0;
			end
			if (mac_req.start) begin
				issued_q <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (item.operation == OP_SAMPLE) begin
							tick_count_q <= '0;
							state_q      <= S_DIV;
						end else begin
							if (tick_count_q != 16'hFFFF) begin
								tick_count_q <= tick_count_q + 16'd1;
							end
							if (beep_flag_q && (buzz_next <= {1'b0, beep_on_q})) begin
								buzzer_count_q <= buzz_next[7:0];
								buzzer_level_q <= 1'b1;
							end else begin
								buzzer_count_q <= '0;
								buzzer_level_q <= 1'b0;
							end
							state_q <= S_DONE;
						end
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_BATT;
					end
				end
				S_BATT: begin
					if (mac_rsp.valid) begin
						issued_q <= 1'b0;
						state_q  <= S_PROBE;
					end
				end
				S_PROBE: begin
					if (mac_rsp.valid) begin
						issued_q    <= 1'b0;
						mode_q      <= mode_n;
						beep_flag_q <= beep_n;
						state_q     <= S_BREF;
					end
				end
				S_BREF: begin
					if (mac_rsp.valid) begin
						issued_q  <= 1'b0;
						avg_ref_q <= mac_rsp.value;
						state_q   <= S_BBAT;
					end
				end
				S_BBAT: begin
					if (mac_rsp.valid) begin
						issued_q      <= 1'b0;
						avg_battery_q <= mac_rsp.value;
						state_q       <= S_BPRB;
					end
				end
				S_BPRB: begin
					if (mac_rsp.valid) begin
						issued_q    <= 1'b0;
						avg_probe_q <= mac_rsp.value;
						first_q     <= 1'b0;
						state_q     <= S_DONE;
					end
				end
				S_DONE: begin
					if (!result_valid_q || !result_stall) begin
						result_valid_q <= 1'b1;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			probe_q    <= item.probe_code;
			batt_q     <= item.battery_code;
			ref_zero_q <= (item.reference_code == '0);
			key_q      <= item.key_pressed;
		end
		if (state_q == S_DIV && div_done) begin
			vref_q <= ref_zero_q ? VREF_MAX : 31'(div_quo);
		end
		if (state_q == S_BATT && mac_rsp.valid) begin
			vbatt_q <= mac_rsp.value;
		end
		if (state_q == S_PROBE && mac_rsp.valid) begin
			vprobe_q <= mac_rsp.value;
		end
		if (state_q == S_DONE && (!result_valid_q || !result_stall)) begin
			result_q.buzzer_on     <= buzzer_level_q;
			result_q.sample_due    <= tick_count_q >= update_period_q;
			result_q.meter_mode    <= mode_q;
			result_q.probe_volts   <= avg_probe_q;
			result_q.battery_volts <= avg_battery_q;
			result_q.beep_request  <= beep_flag_q;
			if (mode_q == MODE_CONTINUITY) begin
				result_q.third_value <= $signed({1'b0, short_thresh_q});
			end else if (mode_q == MODE_JUNCTION) begin
				result_q.third_value <= $signed({1'b0, diode_thresh_q});
			end else begin
				result_q.third_value <= avg_ref_q;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

	a_sample_to_div: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.operation == OP_SAMPLE) |=> (state_q == S_DIV))
		else $error("accepted sample did not start division");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == S_DONE))
		else $error("result loaded outside done step");

	a_mode_legal: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_VOLT || mode_q == MODE_CONTINUITY || mode_q == MODE_JUNCTION))
		else $error("meter mode out of range");

endmodule

// ===== test/meter_reading_check.sv =====
// ----------------------------------------------------------------------------
// Probe meter reading check
// Watches the item, result and register write channels of the probe meter
// front end. Keeps its own copy of the meter state and registers, works out
// the reading each accepted item should produce and compares it, field by
// field, with the readings that come out. Mismatches are counted for the
// testbench top.
// ----------------------------------------------------------------------------
module meter_reading_check (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic              item_stall,
	input  pmfe_pkg::item_t   item,
	input  logic              result_valid,
	input  logic              result_stall,
	input  pmfe_pkg::result_t result,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [30:0]       cfg_data,
	output int                reading_errors,
	output int                readings_owed
);
	timeunit 1ns;
	timeprecision 1ps;
	import pmfe_pkg::*;

	localparam longint S32_MAX = 64'sh7FFF_FFFF;
	localparam longint S32_MIN = -64'sh8000_0000;

	logic [15:0] period;
	logic [11:0] ref_cal;
	logic [11:0] offset;
	logic [16:0] w_probe;
	logic [16:0] w_supply;
	logic [30:0] th_short;
	logic [30:0] th_diode;
	logic [7:0]  beep_len;

	logic [15:0]        ticks;
	logic [7:0]         buzz_count;
	logic               buzz_level;
	logic               beep_flag;
	logic [1:0]         mode;
	logic               first;
	logic signed [31:0] avg_probe;
	logic signed [31:0] avg_batt;
	logic signed [31:0] avg_ref;

	result_t due_readings[$];

	function automatic longint round_shift(longint v, int sh);
		longint mag;
		mag = (v < 0) ? -v : v;
		mag = (mag + (longint'(1) << (sh - 1))) >> sh;
		return (v < 0) ? -mag : mag;
	endfunction

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > S32_MAX)
			return 32'sh7FFF_FFFF;
		if (v < S32_MIN)
			return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] smooth(logic signed [31:0] avg,
			logic signed [31:0] x, logic [16:0] w);
		longint wl;
		longint d;
		wl = (w > Q_ONE) ? longint'(Q_ONE) : longint'(w);
		d = longint'(x) - longint'(avg);
		return clamp32(longint'(avg) + round_shift(d * wl, 16));
	endfunction

	task automatic flag_reading(string msg);
		$display("%0t ns: reading mismatch: %s", $time, msg);
		reading_errors++;
	endtask

	task automatic advance_meter(input item_t it);
		result_t            r;
		longint             num;
		longint             raw;
		logic signed [31:0] vref;
		logic signed [31:0] vbatt;
		logic signed [31:0] vprobe;
		logic [8:0]         next_count;
		if (it.operation == OP_TICK) begin
			if (ticks != 16'hFFFF)
				ticks++;
			if (beep_flag) begin
				next_count = buzz_count + 9'd1;
				if (next_count > {1'b0, beep_len}) begin
					buzz_count = '0;
					buzz_level = 1'b0;
				end else begin
					buzz_count = next_count[7:0];
					buzz_level = 1'b1;
				end
			end else begin
				buzz_count = '0;
				buzz_level = 1'b0;
			end
		end else begin
			ticks = '0;
			if (it.reference_code == '0) begin
				vref = 32'sh7FFF_FFFF;
			end else begin
				num = 3 * longint'(ref_cal) * 65536;
				vref = clamp32((num + longint'(it.reference_code) / 2)
					/ longint'(it.reference_code));
			end
			vbatt = clamp32(round_shift(longint'(it.battery_code) * longint'(vref) * 2,
				ADC_BITS));
			vprobe = clamp32(round_shift((longint'(it.probe_code) - longint'(offset))
				* longint'(vref) * 17, ADC_BITS + 1));
			if (first) begin
				avg_ref = vref;
				avg_batt = vbatt;
				avg_probe = vprobe;
				first = 1'b0;
			end else begin
				avg_ref = smooth(avg_ref, vref, w_supply);
				avg_batt = smooth(avg_batt, vbatt, w_supply);
				avg_probe = smooth(avg_probe, vprobe, w_probe);
			end
			raw = longint'(vprobe);
			if (it.key_pressed) begin
				mode = (mode >= MODE_JUNCTION) ? MODE_VOLT : mode + 2'd1;
				beep_flag = 1'b0;
				if (mode != MODE_VOLT)
					raw = longint'(FIVE_VOLTS);
			end
			if (mode == MODE_CONTINUITY)
				beep_flag = raw < longint'(th_short);
			else if (mode == MODE_JUNCTION)
				beep_flag = raw < longint'(th_diode);
		end
		r.buzzer_on = buzz_level;
		r.sample_due = ticks >= period;
		r.meter_mode = mode;
		r.probe_volts = avg_probe;
		r.battery_volts = avg_batt;
		case (mode)
			MODE_CONTINUITY: r.third_value = signed'({1'b0, th_short});
			MODE_JUNCTION:   r.third_value = signed'({1'b0, th_diode});
			default:         r.third_value = avg_ref;
		endcase
		r.beep_request = beep_flag;
		due_readings.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			period = 16'd50;
			ref_cal = 12'd1650;
			offset = 12'd50;
			w_probe = 17'd32768;
			w_supply = 17'd13107;
			th_short = 31'd32768;
			th_diode = 31'd65536;
			beep_len = 8'd5;
			ticks = '0;
			buzz_count = '0;
			buzz_level = 1'b0;
			beep_flag = 1'b0;
			mode = MODE_VOLT;
			first = 1'b1;
			avg_probe = '0;
			avg_batt = '0;
			avg_ref = '0;
			due_readings.delete();
			reading_errors = 0;
			readings_owed <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_UPDATE_PERIOD: period = cfg_data[15:0];
					REG_REF_CAL:       ref_cal = cfg_data[11:0];
					REG_PROBE_OFFSET:  offset = cfg_data[11:0];
					REG_PROBE_WEIGHT:  w_probe = cfg_data[16:0];
					REG_SUPPLY_WEIGHT: w_supply = cfg_data[16:0];
					REG_SHORT_THRESH:  th_short = cfg_data;
					REG_DIODE_THRESH:  th_diode = cfg_data;
					REG_BEEP_ON_TICKS: beep_len = cfg_data[7:0];
					default: ;
				endcase
			end
			if (item_valid && !item_stall)
				advance_meter(item);
			if (result_valid && !result_stall) begin
				if (due_readings.size() == 0) begin
					flag_reading("result transaction with no reading due");
				end else begin
					want = due_readings.pop_front();
					if (result.buzzer_on !== want.buzzer_on)
						flag_reading($sformatf("buzzer_on got %0b want %0b",
							result.buzzer_on, want.buzzer_on));
					if (result.sample_due !== want.sample_due)
						flag_reading($sformatf("sample_due got %0b want %0b",
							result.sample_due, want.sample_due));
					if (result.meter_mode !== want.meter_mode)
						flag_reading($sformatf("meter_mode got %0d want %0d",
							result.meter_mode, want.meter_mode));
					if (result.probe_volts !== want.probe_volts)
						flag_reading($sformatf("probe_volts got %0d want %0d",
							result.probe_volts, want.probe_volts));
					if (result.battery_volts !== want.battery_volts)
						flag_reading($sformatf("battery_volts got %0d want %0d",
							result.battery_volts, want.battery_volts));
					if (result.third_value !== want.third_value)
						flag_reading($sformatf("third_value got %0d want %0d",
							result.third_value, want.third_value));
					if (result.beep_request !== want.beep_request)
						flag_reading($sformatf("beep_request got %0b want %0b",
							result.beep_request, want.beep_request));
				end
			end
			readings_owed <= due_readings.size();
		end
	end

endmodule

// ===== test/tb_probe_meter_front_end.sv =====
// ----------------------------------------------------------------------------
// Probe meter front end testbench
// Drives tick and sample transactions with random gaps and result stalls
// under several register settings, extremes included, and leaves checking
// of every reading to the reading check beside the block.
// ----------------------------------------------------------------------------
module tb_probe_meter_front_end;
	timeunit 1ns;
	timeprecision 1ps;
	import pmfe_pkg::*;

	typedef logic [ADC_BITS-1:0] code_t;
	localparam int CODE_MAX = (1 << ADC_BITS) - 1;
	localparam int PHASE_ITEMS = 255;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	item_t       item;
	logic        result_valid;
	logic        result_stall;
	result_t     result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [30:0] cfg_data;
	int          reading_errors;
	int          readings_owed;
	int          send_idle_pct = 31;
	int          recv_stall_pct = 87;

	probe_meter_front_end dut (.*);

	meter_reading_check reading_check (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			result_stall = $urandom_range(99) < recv_stall_pct;
		end
	end

	initial begin
		#10ms;
		$display("Regression FAIL");
		$finish;
	end

	function automatic code_t pick_code(bit lean_low);
		case ($urandom_range(7))
			0:       return '0;
			1:       return code_t'(CODE_MAX);
			2, 3:    return lean_low ? code_t'($urandom_range(300))
				: code_t'($urandom_range(CODE_MAX));
			default: return code_t'($urandom_range(CODE_MAX));
		endcase
	endfunction

	function automatic item_t random_item();
		item_t it;
		it.operation = ($urandom_range(99) < 35) ? OP_SAMPLE : OP_TICK;
		it.probe_code = pick_code(1'b1);
		it.battery_code = pick_code(1'b0);
		it.reference_code = ($urandom_range(40) == 0) ? code_t'(0) : pick_code(1'b0);
		it.key_pressed = $urandom_range(99) < 20;
		return it;
	endfunction

	function automatic logic [30:0] with_junk(logic [30:0] v, int w);
		return v | (31'($urandom) << w);
	endfunction

	task automatic offer_item(input item_t it);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid = 1'b0;
			@(negedge clk);
		end
		item = it;
		item_valid = 1'b1;
		do
			@(posedge clk);
		while (item_stall);
	endtask

	task automatic tick_items(int n);
		item_t it;
		for (int i = 0; i < n; i++) begin
			it = random_item();
			it.operation = OP_TICK;
			offer_item(it);
		end
	endtask

	task automatic sample_item(int p, int b, int r, bit k);
		item_t it;
		it.operation = OP_SAMPLE;
		it.probe_code = code_t'(p);
		it.battery_code = code_t'(b);
		it.reference_code = code_t'(r);
		it.key_pressed = k;
		offer_item(it);
	endtask

	task automatic set_reg(logic [2:0] idx, logic [30:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic settle();
		@(negedge clk);
		item_valid = 1'b0;
		wait (readings_owed == 0);
	endtask

	task automatic program_settings(int kind);
		logic [30:0] period, cal, ofs, wp, ws, ths, thd, blen;
		case (kind)
			1: begin
				period = '0;
				cal = '0;
				ofs = '0;
				wp = '0;
				ws = '0;
				ths = '0;
				thd = '0;
				blen = '0;
			end
			3: begin
				period = 31'hFFFF;
				cal = 31'hFFF;
				ofs = 31'hFFF;
				wp = 31'h1FFFF;
				ws = 31'(Q_ONE);
				ths = 31'h7FFF_FFFF;
				thd = 31'h7FFF_FFFF;
				blen = 31'hFF;
			end
			default: begin
				period = with_junk(31'($urandom_range(10, 1)), 16);
				cal = with_junk(31'($urandom_range(CODE_MAX)), 12);
				ofs = with_junk(31'($urandom_range(300)), 12);
				wp = with_junk(31'($urandom_range(Q_ONE)), 17);
				ws = with_junk(31'($urandom_range(Q_ONE)), 17);
				ths = 31'($urandom_range(4 << 16));
				thd = 31'($urandom_range(8 << 16));
				blen = with_junk(31'($urandom_range(8, 1)), 8);
			end
		endcase
		set_reg(REG_UPDATE_PERIOD, period);
		set_reg(REG_REF_CAL, cal);
		set_reg(REG_PROBE_OFFSET, ofs);
		set_reg(REG_PROBE_WEIGHT, wp);
		set_reg(REG_SUPPLY_WEIGHT, ws);
		set_reg(REG_SHORT_THRESH, ths);
		set_reg(REG_DIODE_THRESH, thd);
		set_reg(REG_BEEP_ON_TICKS, blen);
	endtask

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_UPDATE_PERIOD;
		cfg_data = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		tick_items(1);
		sample_item(CODE_MAX, CODE_MAX, 0, 1'b0);
		sample_item(0, 0, CODE_MAX, 1'b0);
		sample_item(50, 2048, 1650, 1'b1);
		sample_item(60, 1000, 1650, 1'b0);
		tick_items(7);
		sample_item(100, 1500, 1650, 1'b1);
		sample_item(200, 1500, 1650, 1'b0);
		tick_items(3);
		sample_item(CODE_MAX, CODE_MAX, 1, 1'b1);
		tick_items(2);

		for (int ph = 0; ph < 6; ph++) begin
			settle();
			if (ph == 2) begin
				send_idle_pct = 87;
				recv_stall_pct = 31;
			end else if (ph == 4) begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			program_settings(ph);
			for (int i = 0; i < PHASE_ITEMS; i++)
				offer_item(random_item());
		end

		settle();
		repeat (100) @(posedge clk);
		if (reading_errors == 0 && readings_owed == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== probe_meter_front_end.f =====
hdl/pmfe_pkg.sv
hdl/pmfe_div.sv
hdl/pmfe_mac.sv
hdl/probe_meter_front_end.sv
test/meter_reading_check.sv
test/tb_probe_meter_front_end.sv
